>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/tpt_pkg.sv
package tpt_pkg;

  localparam int CHANNELS_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CH_FIELD_W   = 4;
  localparam int PROB_W       = 17;
  localparam int RAND_W       = 16;
  localparam int PULSE_W      = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int MODE_W       = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_DETECT_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_MODE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_TICKS = 2'd2;

  // detection modes
  localparam logic [MODE_W-1:0] DET_SLOPE  = 2'd0;
  localparam logic [MODE_W-1:0] DET_CROSS  = 2'd1;
  localparam logic [MODE_W-1:0] DET_EITHER = 2'd2;

  localparam logic [PULSE_W-1:0] PULSE_TICKS_RESET = 16'd48;

  typedef struct packed {
    logic [MODE_W-1:0]  detect_mode;
    logic               latch_mode;
    logic [PULSE_W-1:0] pulse_ticks;
  } cfg_t;

endpackage

>>> rtl/core/tpt_ifs.sv
interface tpt_in_if #(
  parameter int SAMPLE_BITS = tpt_pkg::SAMPLE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [tpt_pkg::CH_FIELD_W-1:0]    channel;
  logic signed [SAMPLE_BITS-1:0]     sample;
  logic signed [SAMPLE_BITS-1:0]     threshold;
  logic [tpt_pkg::PROB_W-1:0]        probability;
  logic [tpt_pkg::RAND_W-1:0]        random_value;

  modport source (output valid, channel, sample, threshold, probability, random_value,
                  input ready);
  modport sink (input valid, channel, sample, threshold, probability, random_value,
                output ready);
endinterface

interface tpt_out_if;
  logic                           valid;
  logic                           ready;
  logic [tpt_pkg::CH_FIELD_W-1:0] out_channel;
  logic                           gate;
  logic                           fired;

  modport source (output valid, out_channel, gate, fired, input ready);
  modport sink (input valid, out_channel, gate, fired, output ready);
endinterface

interface tpt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tpt_pkg::CFG_INDEX_W-1:0] index;
  logic [tpt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/tpt_cfg_regs.sv
module tpt_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  tpt_cfg_if.sink        cfg,
  output tpt_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.detect_mode <= tpt_pkg::DET_SLOPE;
      regs.latch_mode  <= 1'b0;
      regs.pulse_ticks <= tpt_pkg::PULSE_TICKS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tpt_pkg::REG_DETECT_MODE: regs.detect_mode <= cfg.data[tpt_pkg::MODE_W-1:0];
        tpt_pkg::REG_LATCH_MODE:  regs.latch_mode  <= cfg.data[0];
        tpt_pkg::REG_PULSE_TICKS: regs.pulse_ticks <= cfg.data[tpt_pkg::PULSE_W-1:0];
        default: ;  // unmapped index: drop the beat
      endcase
    end
  end

endmodule

>>> rtl/core/tpt_state_mem.sv
module tpt_state_mem #(
  parameter int DEPTH  = tpt_pkg::CHANNELS_DEF,
  parameter int WIDTH  = 3 * tpt_pkg::SAMPLE_BITS_DEF + tpt_pkg::PULSE_W + 1,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  filled;
  logic [WIDTH-1:0]  rd_q;
  logic              rd_filled;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [WIDTH-1:0]  fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      fwd_addr     <= wr_addr;
      fwd_data     <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      fwd_valid <= 1'b0;
      rd_filled <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
        fwd_valid       <= 1'b1;
      end
      if (rd_en) begin
        rd_filled <= filled[rd_addr];
      end
    end
  end

  // A matching last write is the newest data; it covers a write on the read edge.
  always_comb begin
    if (fwd_valid && fwd_addr == rd_addr_q) begin
      rd_data = fwd_data;
    end else if (rd_filled) begin
      rd_data = rd_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

>>> rtl/core/tpt_core.sv
module tpt_core #(
  parameter int SAMPLE_BITS = tpt_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_W     = 3 * SAMPLE_BITS + tpt_pkg::PULSE_W + 1
) (
  input  tpt_pkg::cfg_t                  regs,
  input  logic                           in_range,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic signed [SAMPLE_BITS-1:0]  threshold,
  input  logic [tpt_pkg::PROB_W-1:0]     probability,
  input  logic [tpt_pkg::RAND_W-1:0]     random_value,
  input  logic [STATE_W-1:0]             state,
  output logic [STATE_W-1:0]             state_next,
  output logic                           gate,
  output logic                           fired
);

  logic signed [SAMPLE_BITS-1:0] newest;
  logic signed [SAMPLE_BITS-1:0] middle;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic [tpt_pkg::PULSE_W-1:0]   pulse;
  logic                          latched;

  logic                          shift;
  logic signed [SAMPLE_BITS-1:0] v1;
  logic signed [SAMPLE_BITS-1:0] v2;
  logic signed [SAMPLE_BITS-1:0] v3;
  logic                          rev;
  logic                          crossing;
  logic                          det;
  logic                          fire;
  logic [tpt_pkg::PULSE_W-1:0]   pulse_armed;
  logic                          pulse_high;
  logic [tpt_pkg::PULSE_W-1:0]   pulse_next;
  logic                          latched_next;

  assign {newest, middle, oldest, pulse, latched} = state;

  assign shift = sample != newest;
  assign v1    = sample;
  assign v2    = newest;
  assign v3    = middle;

  assign rev      = (v2 > v1 && v3 < v2) || (v2 < v1 && v3 > v2);
  assign crossing = (v1 > threshold && v2 <= threshold)
                    || (v1 < threshold && v2 >= threshold);

  always_comb begin
    unique case (regs.detect_mode)
      tpt_pkg::DET_SLOPE:  det = rev;
      tpt_pkg::DET_CROSS:  det = crossing;
      tpt_pkg::DET_EITHER: det = rev || crossing;
      default:             det = 1'b0;
    endcase
  end

  assign fire = shift && det && ({1'b0, random_value} < probability);

  // extend the pulse to at least the configured length
  assign pulse_armed  = (fire && !regs.latch_mode && pulse < regs.pulse_ticks)
                        ? regs.pulse_ticks : pulse;
  assign pulse_high   = pulse_armed != '0;
  assign pulse_next   = (regs.latch_mode || !pulse_high)
                        ? pulse_armed : pulse_armed - tpt_pkg::PULSE_W'(1);
  assign latched_next = (fire && regs.latch_mode) ? !latched : latched;

  assign state_next = shift
                      ? {sample, newest, middle, pulse_next, latched_next}
                      : {newest, middle, oldest, pulse_next, latched_next};

  assign gate  = in_range && (regs.latch_mode ? latched_next : pulse_high);
  assign fired = in_range && fire;

endmodule

>>> rtl/core/turning_point_trigger.sv
// Per-channel turning point trigger for up to CHANNELS interleaved channels.
// samples: one beat per sample carrying channel, sample, threshold,
//   probability and random_value. results: one beat per sample with
//   out_channel, gate and fired. cfg: register writes (index, data); index 0
//   detect_mode, 1 latch_mode, 2 pulse_ticks. cfg.ready is always high.
// Throughput: one sample per cycle unless the result side stalls, in any
//   channel order, the same channel back to back included. The per-channel
//   history lives in a registered-read memory that forwards the last write.
// Pipeline: an accepted sample waits in the input stage and its result is
//   registered in the result register when that stage advances.
// Stall: the result register and the input stage hold while results.valid is
//   high and results.ready low; samples.ready drops only when both are full.
// Reset: clears the registers to detect_mode 0, latch_mode 0, pulse_ticks 48
//   and marks every channel's history, pulse and latch as zero. No clearing
//   pass is run; samples are taken in the first cycle after reset.
// Channels at or above CHANNELS give gate 0, fired 0 and change no state.
`include "assert_macros.svh"

module turning_point_trigger #(
  parameter int CHANNELS    = tpt_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = tpt_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tpt_cfg_if.sink    cfg,
  tpt_in_if.sink     samples,
  tpt_out_if.source  results
);

  localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STATE_W = 3 * SAMPLE_BITS + tpt_pkg::PULSE_W + 1;
  localparam int CMP_W   = 8;

  tpt_pkg::cfg_t regs;

  logic                           s1_valid;
  logic                           s1_in_range;
  logic [tpt_pkg::CH_FIELD_W-1:0] s1_channel;
  logic [ADDR_W-1:0]              s1_addr;
  logic signed [SAMPLE_BITS-1:0]  s1_sample;
  logic signed [SAMPLE_BITS-1:0]  s1_threshold;
  logic [tpt_pkg::PROB_W-1:0]     s1_probability;
  logic [tpt_pkg::RAND_W-1:0]     s1_random_value;

  logic                           accept;
  logic                           s1_adv;
  logic                           in_range;
  logic [ADDR_W-1:0]              in_addr;
  logic [STATE_W-1:0]             state;
  logic [STATE_W-1:0]             state_next;
  logic                           res_gate;
  logic                           res_fired;

  tpt_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign s1_adv        = s1_valid && (!results.valid || results.ready);
  assign samples.ready = !s1_valid || s1_adv;
  assign accept        = samples.valid && samples.ready;

  assign in_range = CMP_W'(samples.channel) < CMP_W'(CHANNELS);
  assign in_addr  = ADDR_W'(samples.channel);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range     <= in_range;
      s1_channel      <= samples.channel;
      s1_addr         <= in_addr;
      s1_sample       <= samples.sample;
      s1_threshold    <= samples.threshold;
      s1_probability  <= samples.probability;
      s1_random_value <= samples.random_value;
    end
  end

  tpt_state_mem #(
    .DEPTH  (CHANNELS),
    .WIDTH  (STATE_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_addr (in_addr),
    .wr_en   (s1_adv && s1_in_range),
    .wr_addr (s1_addr),
    .wr_data (state_next),
    .rd_data (state)
  );

  tpt_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_W     (STATE_W)
  ) u_core (
    .regs         (regs),
    .in_range     (s1_in_range),
    .sample       (s1_sample),
    .threshold    (s1_threshold),
    .probability  (s1_probability),
    .random_value (s1_random_value),
    .state        (state),
    .state_next   (state_next),
    .gate         (res_gate),
    .fired        (res_fired)
  );

  // result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (!results.valid || results.ready) begin
      results.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      results.out_channel <= s1_channel;
      results.gate        <= res_gate;
      results.fired       <= res_fired;
    end
  end

  `ASSERT_SAME(a_fire_in_range, clk, rst, results.valid && results.fired,
               results.out_channel < CHANNELS)
  `ASSERT_SAME(a_idle_channel_low, clk, rst,
               results.valid && results.out_channel >= CHANNELS,
               !results.gate && !results.fired)
  `ASSERT_SAME(a_pulse_on_fire, clk, rst,
               s1_adv && res_fired && !regs.latch_mode && regs.pulse_ticks != '0,
               res_gate)
  `ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !s1_adv,
               s1_valid && $stable(s1_channel) && $stable(s1_sample))

endmodule

>>> tb/tb_turning_point_trigger.sv
`timescale 1ns / 1ps

module tb_turning_point_trigger;

  localparam int CYCLE_LIMIT = 300000;
  // codes the package leaves unnamed
  localparam logic [tpt_pkg::MODE_W-1:0]      DET_UNUSED = 2'd3;
  localparam logic [tpt_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [tpt_pkg::CH_FIELD_W-1:0]             channel;
    logic signed [tpt_pkg::SAMPLE_BITS_DEF-1:0] sample;
    logic signed [tpt_pkg::SAMPLE_BITS_DEF-1:0] threshold;
    logic [tpt_pkg::PROB_W-1:0]                 probability;
    logic [tpt_pkg::RAND_W-1:0]                 random_value;
  } sample_beat_t;

  typedef struct packed {
    logic [tpt_pkg::CH_FIELD_W-1:0] channel;
    logic                           gate;
    logic                           fired;
  } trig_result_t;

  logic clk;
  logic rst;

  tpt_cfg_if                                          cfg_bus ();
  tpt_in_if #(.SAMPLE_BITS(tpt_pkg::SAMPLE_BITS_DEF)) smp_bus ();
  tpt_out_if                                          res_bus ();

  turning_point_trigger #(
    .CHANNELS    (tpt_pkg::CHANNELS_DEF),
    .SAMPLE_BITS (tpt_pkg::SAMPLE_BITS_DEF)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (smp_bus),
    .results (res_bus)
  );

  // trigger state as the block should hold it
  tpt_pkg::cfg_t                              cfg_shadow;
  logic signed [tpt_pkg::SAMPLE_BITS_DEF-1:0] hist_new   [tpt_pkg::CHANNELS_DEF];
  logic signed [tpt_pkg::SAMPLE_BITS_DEF-1:0] hist_mid   [tpt_pkg::CHANNELS_DEF];
  logic signed [tpt_pkg::SAMPLE_BITS_DEF-1:0] hist_old   [tpt_pkg::CHANNELS_DEF];
  logic [tpt_pkg::PULSE_W-1:0]                pulse_left [tpt_pkg::CHANNELS_DEF];
  logic                                       latch_level[tpt_pkg::CHANNELS_DEF];

  trig_result_t trig_expect_q[$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  bit           pace_idle   = 1'b1;
  int           hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic trig_result_t predict_trigger(sample_beat_t b);
    trig_result_t r;
    int           v1, v2, v3, d1, d2, thr;
    bit           rev, crossing, det;
    r.channel = b.channel;
    r.gate    = 1'b0;
    r.fired   = 1'b0;
    if (b.sample != hist_new[b.channel]) begin
      hist_old[b.channel] = hist_mid[b.channel];
      hist_mid[b.channel] = hist_new[b.channel];
      hist_new[b.channel] = b.sample;
      v1  = hist_new[b.channel];
      v2  = hist_mid[b.channel];
      v3  = hist_old[b.channel];
      thr = $signed(b.threshold);
      d1  = v2 - v1;
      d2  = v3 - v2;
      rev      = (d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0);
      crossing = (v1 > thr && v2 <= thr) || (v1 < thr && v2 >= thr);
      case (cfg_shadow.detect_mode)
        tpt_pkg::DET_SLOPE:  det = rev;
        tpt_pkg::DET_CROSS:  det = crossing;
        tpt_pkg::DET_EITHER: det = rev || crossing;
        default:             det = 1'b0;
      endcase
      r.fired = det && (int'(b.random_value) < int'(b.probability));
      if (r.fired) begin
        if (!cfg_shadow.latch_mode) begin
          if (pulse_left[b.channel] < cfg_shadow.pulse_ticks)
            pulse_left[b.channel] = cfg_shadow.pulse_ticks;
        end else begin
          latch_level[b.channel] = ~latch_level[b.channel];
        end
      end
    end
    if (cfg_shadow.latch_mode) begin
      r.gate = latch_level[b.channel];
    end else if (pulse_left[b.channel] != '0) begin
      r.gate = 1'b1;
      pulse_left[b.channel] = pulse_left[b.channel] - 1'b1;
    end
    return r;
  endfunction

  function automatic sample_beat_t make_beat(int ch, int s, int thr, int prob, int rnd);
    sample_beat_t b;
    b.channel      = 4'(ch);
    b.sample       = 16'(s);
    b.threshold    = 16'(thr);
    b.probability  = 17'(prob);
    b.random_value = 16'(rnd);
    return b;
  endfunction

  // small walks around zero in nearly half the draws so reversals and crossings come often
  function automatic sample_beat_t draw_sample();
    sample_beat_t b;
    int           pick, lvl, step;
    if ($urandom_range(1, 0) == 1) b.channel = 4'($urandom_range(3, 0));
    else b.channel = 4'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < 20) begin
      b.sample = hist_new[b.channel];
    end else if (pick < 30) begin
      b.sample = ($urandom_range(1, 0) == 1) ? 16'sh7fff : 16'sh8000;
    end else if (pick < 75) begin
      step = int'($urandom_range(600, 0)) - 300;
      lvl  = int'(hist_new[b.channel]) + step;
      if (lvl > 3000) lvl = 3000;
      if (lvl < -3000) lvl = -3000;
      b.sample = 16'(lvl);
    end else begin
      b.sample = 16'($urandom);
    end
    if ($urandom_range(1, 0) == 1) begin
      b.threshold = 16'($urandom);
    end else begin
      lvl = int'($urandom_range(1000, 0)) - 500;
      b.threshold = 16'(lvl);
    end
    pick = $urandom_range(99, 0);
    if (pick < 10) b.probability = '0;
    else if (pick < 25) b.probability = 17'd65536;
    else if (pick < 35) b.probability = 17'(65537 + $urandom_range(65534, 0));
    else b.probability = 17'($urandom_range(65536, 0));
    b.random_value = 16'($urandom);
    return b;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  task automatic send_beat(sample_beat_t b);
    int gap;
    gap = pace_idle ? $urandom_range(16, 0) : 0;
    repeat (gap) begin
      @(negedge clk);
      smp_bus.valid = 1'b0;
    end
    @(negedge clk);
    smp_bus.valid        = 1'b1;
    smp_bus.channel      = b.channel;
    smp_bus.sample       = b.sample;
    smp_bus.threshold    = b.threshold;
    smp_bus.probability  = b.probability;
    smp_bus.random_value = b.random_value;
    do @(posedge clk); while (!smp_bus.ready);
    trig_expect_q.push_back(predict_trigger(b));
  endtask

  // drop valid and hold until every result is back
  task automatic wait_drain();
    @(negedge clk);
    smp_bus.valid = 1'b0;
    while (trig_expect_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [tpt_pkg::CFG_INDEX_W-1:0] idx,
                           logic [tpt_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      tpt_pkg::REG_DETECT_MODE: cfg_shadow.detect_mode = val[tpt_pkg::MODE_W-1:0];
      tpt_pkg::REG_LATCH_MODE:  cfg_shadow.latch_mode  = val[0];
      tpt_pkg::REG_PULSE_TICKS: cfg_shadow.pulse_ticks = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_config(logic [tpt_pkg::MODE_W-1:0] det, logic latch,
                            logic [tpt_pkg::PULSE_W-1:0] ticks);
    wait_drain();
    write_reg(tpt_pkg::REG_DETECT_MODE, tpt_pkg::CFG_DATA_W'(det));
    write_reg(tpt_pkg::REG_LATCH_MODE, tpt_pkg::CFG_DATA_W'(latch));
    write_reg(tpt_pkg::REG_PULSE_TICKS, ticks);
  endtask

  // reset settings: slope reversal, pulse of 48
  task automatic test_slope_pulse();
    send_beat(make_beat(0, 100, 0, 65536, 65535));
    send_beat(make_beat(0, 200, 0, 65536, 65535));
    send_beat(make_beat(0, 200, 0, 65536, 0));
    send_beat(make_beat(0, 100, 0, 65536, 65535));
    send_beat(make_beat(0, -32768, 0, 0, 0));
    send_beat(make_beat(0, 32767, 0, 0, 0));
    send_beat(make_beat(0, -32768, 0, 131071, 65535));
    send_beat(make_beat(15, 0, 0, 65536, 0));
    send_beat(make_beat(15, -1, 0, 65536, 0));
    send_beat(make_beat(15, 1, 0, 65536, 0));
  endtask

  task automatic test_cross_latch();
    set_config(tpt_pkg::DET_CROSS, 1'b1, tpt_pkg::PULSE_TICKS_RESET);
    send_beat(make_beat(5, -32768, -32768, 65536, 0));
    send_beat(make_beat(5, 32767, 32767, 65536, 0));
    send_beat(make_beat(5, 1, 0, 65536, 0));
    send_beat(make_beat(5, -1, 0, 1000, 1000));
    send_beat(make_beat(5, 1, 0, 1000, 999));
    send_beat(make_beat(5, 0, 0, 65536, 0));
  endtask

  task automatic test_mode_corners();
    set_config(tpt_pkg::DET_EITHER, 1'b0, 16'd0);
    send_beat(make_beat(2, 50, 0, 65536, 0));
    send_beat(make_beat(2, -50, 0, 65536, 0));
    set_config(tpt_pkg::DET_EITHER, 1'b0, 16'd1);
    send_beat(make_beat(2, 50, 0, 65536, 0));
    send_beat(make_beat(2, 60, 0, 65536, 0));
    set_config(DET_UNUSED, 1'b0, 16'hffff);
    send_beat(make_beat(3, 10, 0, 65536, 0));
    send_beat(make_beat(3, -10, 0, 65536, 0));
    // out-of-range index must leave the registers alone
    wait_drain();
    write_reg(REG_UNUSED, 16'hffff);
    write_reg(tpt_pkg::REG_DETECT_MODE, 16'hfffe);
    send_beat(make_beat(3, 10, 0, 65536, 0));
    send_beat(make_beat(3, -10, 0, 65536, 0));
    send_beat(make_beat(3, 20, 0, 65536, 0));
  endtask

  task automatic test_random_phases();
    logic [tpt_pkg::PULSE_W-1:0] ticks;
    logic [tpt_pkg::MODE_W-1:0]  det;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       ticks = 16'd1;
        1:       ticks = 16'hffff;
        2:       ticks = 16'd0;
        3, 4:    ticks = 16'($urandom_range(64, 1));
        default: ticks = 16'($urandom);
      endcase
      det = (p == 6) ? DET_UNUSED : tpt_pkg::MODE_W'(p % 3);
      set_config(det, 1'(p % 2), ticks);
      if (p == 4) write_reg(REG_UNUSED, 16'($urandom));
      pace_idle = (p != 3);
      repeat (100) send_beat(draw_sample());
    end
    pace_idle = 1'b1;
  endtask

  // stall the result side long enough that the input backs up
  task automatic test_backpressure();
    set_config(tpt_pkg::DET_EITHER, 1'b0, 16'd8);
    pace_idle   = 1'b0;
    hold_cycles = 300;
    repeat (60) send_beat(draw_sample());
    wait_drain();
    repeat (20) send_beat(draw_sample());
    pace_idle = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    res_bus.ready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk);
        res_bus.ready = 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end
      stall = pace_idle ? $urandom_range(16, 0) : 0;
      if (stall > 0) begin
        @(negedge clk);
        res_bus.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      res_bus.ready = 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  always @(posedge clk) begin : result_check
    trig_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (trig_expect_q.size() == 0) begin
        note_mismatch("unexpected beat, channel", -1, int'(res_bus.out_channel));
      end else begin
        want = trig_expect_q.pop_front();
        if (res_bus.out_channel !== want.channel)
          note_mismatch("out_channel", int'(want.channel), int'(res_bus.out_channel));
        if (res_bus.gate !== want.gate)
          note_mismatch("gate", int'(want.gate), int'(res_bus.gate));
        if (res_bus.fired !== want.fired)
          note_mismatch("fired", int'(want.fired), int'(res_bus.fired));
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    smp_bus.valid        = 1'b0;
    smp_bus.channel      = '0;
    smp_bus.sample       = '0;
    smp_bus.threshold    = '0;
    smp_bus.probability  = '0;
    smp_bus.random_value = '0;
    cfg_shadow.detect_mode = tpt_pkg::DET_SLOPE;
    cfg_shadow.latch_mode  = 1'b0;
    cfg_shadow.pulse_ticks = tpt_pkg::PULSE_TICKS_RESET;
    for (int c = 0; c < tpt_pkg::CHANNELS_DEF; c++) begin
      hist_new[c]    = '0;
      hist_mid[c]    = '0;
      hist_old[c]    = '0;
      pulse_left[c]  = '0;
      latch_level[c] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_slope_pulse();
    test_cross_latch();
    test_mode_corners();
    test_random_phases();
    test_backpressure();

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && trig_expect_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
